// ----- rtl/lld_pkg.sv -----
// Shared types and constants of the linked list deque.
package lld_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int RESULT_LIMIT   = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [3:0] CMD_PUSH_F   = 4'd0;
    localparam logic [3:0] CMD_PUSH_B   = 4'd1;
    localparam logic [3:0] CMD_POP_F    = 4'd2;
    localparam logic [3:0] CMD_POP_B    = 4'd3;
    localparam logic [3:0] CMD_PEEK_F   = 4'd4;
    localparam logic [3:0] CMD_PEEK_B   = 4'd5;
    localparam logic [3:0] CMD_REMOVE   = 4'd6;
    localparam logic [3:0] CMD_CONTAINS = 4'd7;
    localparam logic [3:0] CMD_DUMP_F   = 4'd8;
    localparam logic [3:0] CMD_DUMP_R   = 4'd9;
    localparam logic [3:0] CMD_CLEAR    = 4'd10;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_FIND  = 3'd3,
        OP_DUMP  = 3'd4,
        OP_CLEAR = 3'd5,
        OP_NOP   = 3'd6
    } t_op;

    // alt: back end for push/pop/peek/dump, remove for find
    typedef struct packed {
        t_op         op;
        logic        alt;
        logic [31:0] word;
    } t_qent;

endpackage

// ----- rtl/lld_front.sv -----
// Command intake: classify each beat and hold it in a short queue.
module lld_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [3:0]           i_cmd,
    input  logic signed [31:0]   i_value,
    output logic                 o_q_valid,
    output lld_pkg::t_qent       o_q_entry,
    input  logic                 i_q_pop
);

    lld_pkg::t_qent r_q [lld_pkg::QUEUE_DEPTH];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    lld_pkg::t_qent n_ent;
    logic           push;
    logic           pop;

    always_comb begin
        n_ent.word = i_value;
        n_ent.alt  = 1'b0;
        n_ent.op   = lld_pkg::OP_NOP;
        unique case (i_cmd) inside
            lld_pkg::CMD_PUSH_F, lld_pkg::CMD_PUSH_B: begin
                n_ent.op  = lld_pkg::OP_PUSH;
                n_ent.alt = (i_cmd == lld_pkg::CMD_PUSH_B);
            end
            lld_pkg::CMD_POP_F, lld_pkg::CMD_POP_B: begin
                n_ent.op  = lld_pkg::OP_POP;
                n_ent.alt = (i_cmd == lld_pkg::CMD_POP_B);
            end
            lld_pkg::CMD_PEEK_F, lld_pkg::CMD_PEEK_B: begin
                n_ent.op  = lld_pkg::OP_PEEK;
                n_ent.alt = (i_cmd == lld_pkg::CMD_PEEK_B);
            end
            lld_pkg::CMD_REMOVE, lld_pkg::CMD_CONTAINS: begin
                n_ent.op  = lld_pkg::OP_FIND;
                n_ent.alt = (i_cmd == lld_pkg::CMD_REMOVE);
            end
            lld_pkg::CMD_DUMP_F, lld_pkg::CMD_DUMP_R: begin
                n_ent.op  = lld_pkg::OP_DUMP;
                n_ent.alt = (i_cmd == lld_pkg::CMD_DUMP_R);
            end
            lld_pkg::CMD_CLEAR: n_ent.op = lld_pkg::OP_CLEAR;
            default:            n_ent.op = lld_pkg::OP_NOP;
        endcase
    end

    assign o_stall   = (r_cnt == 2'(lld_pkg::QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_entry = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/lld_back.sv -----
// Command execution: node memories, list pointers and result register.
module lld_back #(
    parameter int CAPACITY   = lld_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = lld_pkg::WORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  lld_pkg::t_qent       i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_item,
    output logic [1:0]           o_status,
    output logic [6:0]           o_count,
    output logic                 o_last
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DW    = (CNT_W >= 7) ? CNT_W + 1 : 8;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_PUSH     = 11'b000_0000_0100,
        S_PUSH2    = 11'b000_0000_1000,
        S_LOOK     = 11'b000_0001_0000,
        S_UNL1     = 11'b000_0010_0000,
        S_UNL2     = 11'b000_0100_0000,
        S_SRCH_RD  = 11'b000_1000_0000,
        S_SRCH_CMP = 11'b001_0000_0000,
        S_DUMP_RD  = 11'b010_0000_0000,
        S_EMIT     = 11'b100_0000_0000
    } t_state;

    logic [WORD_WIDTH-1:0] mem_value [CAPACITY];
    logic [PTR_W-1:0]      mem_next  [CAPACITY];
    logic [PTR_W-1:0]      mem_prev  [CAPACITY];

    logic [WORD_WIDTH-1:0] r_rd_value;
    logic [PTR_W-1:0]      r_rd_next;
    logic [PTR_W-1:0]      r_rd_prev;

    t_state                r_state;
    logic                  r_dump_ld;
    logic [PTR_W-1:0]      r_front;
    logic [PTR_W-1:0]      r_back;
    logic [PTR_W-1:0]      r_free;
    logic [PTR_W-1:0]      r_node;
    logic [PTR_W-1:0]      r_p;
    logic [PTR_W-1:0]      r_sweep;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_idx;
    logic [WORD_WIDTH-1:0] r_word;
    logic                  r_alt;
    logic                  r_rm;
    logic                  r_clr_emit;
    logic [31:0]           r_item;
    lld_pkg::t_status      r_status;
    logic                  r_last;
    logic                  r_more;

    logic                  r_ovalid;
    logic [31:0]           r_oitem;
    lld_pkg::t_status      r_ostatus;
    logic [6:0]            r_ocount;
    logic                  r_olast;

    logic                  re;
    logic [PTR_W-1:0]      ra;
    logic                  we_v;
    logic                  we_n;
    logic                  we_p;
    logic [PTR_W-1:0]      wa_v;
    logic [PTR_W-1:0]      wa_n;
    logic [PTR_W-1:0]      wa_p;
    logic [PTR_W-1:0]      wd_n;
    logic [PTR_W-1:0]      wd_p;
    logic                  out_free;
    logic                  emit;
    logic                  empty;
    logic                  full;
    logic [PTR_W-1:0]      sweep_nxt;
    logic                  dump_fin;
    logic [31:0]           rd_item;

    assign empty     = (r_count == '0);
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign out_free  = !r_ovalid || !i_stall;
    assign emit      = (r_state == S_EMIT) && !r_dump_ld && out_free;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign sweep_nxt = (r_sweep == PTR_W'(CAPACITY - 1)) ? '0 : r_sweep + 1'b1;
    assign rd_item   = 32'(signed'(r_rd_value));
    assign dump_fin  = (DW'(r_idx) + 1'b1 == DW'(r_count)) ||
                       (DW'(r_idx) + 1'b1 == DW'(lld_pkg::RESULT_LIMIT));

    // memory port control
    always_comb begin
        re   = 1'b0;
        ra   = r_p;
        we_v = 1'b0;
        we_n = 1'b0;
        we_p = 1'b0;
        wa_v = r_node;
        wa_n = r_node;
        wa_p = r_node;
        wd_n = r_node;
        wd_p = r_node;
        unique case (r_state)
            S_IDLE: begin
                re = i_q_valid;
                if (i_q_entry.op == lld_pkg::OP_PUSH) begin
                    ra = r_free;
                end else begin
                    ra = i_q_entry.alt ? r_back : r_front;
                end
            end
            S_SRCH_RD, S_DUMP_RD: begin
                re = 1'b1;
                ra = r_p;
            end
            S_PUSH: begin
                we_v = 1'b1;
                we_n = 1'b1;
                we_p = 1'b1;
                wd_n = (!r_alt && !empty) ? r_front : r_node;
                wd_p = (r_alt && !empty) ? r_back : r_node;
            end
            S_PUSH2: begin
                if (!empty) begin
                    if (r_alt) begin
                        we_n = 1'b1;
                        wa_n = r_back;
                    end else begin
                        we_p = 1'b1;
                        wa_p = r_front;
                    end
                end
            end
            S_UNL1: begin
                if (r_count != CNT_W'(1) && r_node != r_front) begin
                    we_n = 1'b1;
                    wa_n = r_rd_prev;
                    wd_n = r_rd_next;
                    if (r_node != r_back) begin
                        we_p = 1'b1;
                        wa_p = r_rd_next;
                        wd_p = r_rd_prev;
                    end
                end
            end
            S_UNL2: begin
                we_n = 1'b1;
                wd_n = r_free;
            end
            S_CLEAR: begin
                we_n = 1'b1;
                wa_n = r_sweep;
                wd_n = sweep_nxt;
            end
            default: begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_v) begin
            mem_value[wa_v] <= r_word;
        end
        if (we_n) begin
            mem_next[wa_n] <= wd_n;
        end
        if (we_p) begin
            mem_prev[wa_p] <= wd_p;
        end
        if (re) begin
            r_rd_value <= mem_value[ra];
            r_rd_next  <= mem_next[ra];
            r_rd_prev  <= mem_prev[ra];
        end
    end

    // payload of the pending result and the walk
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_word   <= WORD_WIDTH'(signed'(i_q_entry.word));
                r_alt    <= i_q_entry.alt;
                r_rm     <= (i_q_entry.op == lld_pkg::OP_POP) ||
                            (i_q_entry.op == lld_pkg::OP_FIND && i_q_entry.alt);
                r_item   <= '0;
                r_last   <= 1'b1;
                r_more   <= 1'b0;
                r_idx    <= '0;
                r_node   <= (i_q_entry.op == lld_pkg::OP_PUSH) ? r_free :
                            (i_q_entry.alt ? r_back : r_front);
                r_p      <= (i_q_entry.op == lld_pkg::OP_DUMP && i_q_entry.alt) ?
                            r_back : r_front;
                r_status <= (i_q_entry.op == lld_pkg::OP_PUSH && full) ?
                                lld_pkg::ST_FULL :
                            (empty && (i_q_entry.op == lld_pkg::OP_POP ||
                                       i_q_entry.op == lld_pkg::OP_PEEK ||
                                       i_q_entry.op == lld_pkg::OP_DUMP)) ?
                                lld_pkg::ST_EMPTY : lld_pkg::ST_OK;
            end
            S_LOOK: begin
                r_item <= rd_item;
            end
            S_SRCH_RD: begin
                if (r_idx == r_count) begin
                    r_status <= lld_pkg::ST_MISSING;
                end
            end
            S_SRCH_CMP: begin
                if (r_rd_value == r_word) begin
                    r_node <= r_p;
                end else begin
                    r_p   <= r_rd_next;
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                if (r_dump_ld) begin
                    r_item <= rd_item;
                    r_last <= dump_fin;
                    r_more <= !dump_fin;
                    r_p    <= r_alt ? r_rd_prev : r_rd_next;
                    r_idx  <= r_idx + 1'b1;
                end
            end
            S_CLEAR: begin
                r_item   <= '0;
                r_status <= lld_pkg::ST_OK;
                r_last   <= 1'b1;
                r_more   <= 1'b0;
            end
            default: begin
                r_item <= r_item;
            end
        endcase
    end

    // sequencer, list pointers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_dump_ld  <= 1'b0;
            r_sweep    <= '0;
            r_clr_emit <= 1'b0;
            r_front    <= '0;
            r_back     <= '0;
            r_free     <= '0;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_sweep <= sweep_nxt;
                    if (r_sweep == PTR_W'(CAPACITY - 1)) begin
                        r_front <= '0;
                        r_back  <= '0;
                        r_free  <= '0;
                        r_count <= '0;
                        r_state <= r_clr_emit ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        unique case (i_q_entry.op)
                            lld_pkg::OP_PUSH:
                                r_state <= full ? S_EMIT : S_PUSH;
                            lld_pkg::OP_POP, lld_pkg::OP_PEEK:
                                r_state <= empty ? S_EMIT : S_LOOK;
                            lld_pkg::OP_FIND:
                                r_state <= S_SRCH_RD;
                            lld_pkg::OP_DUMP:
                                r_state <= empty ? S_EMIT : S_DUMP_RD;
                            lld_pkg::OP_CLEAR: begin
                                r_sweep    <= '0;
                                r_clr_emit <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            default:
                                r_state <= S_EMIT;
                        endcase
                    end
                end
                S_PUSH: begin
                    r_free  <= r_rd_next;
                    r_state <= S_PUSH2;
                end
                S_PUSH2: begin
                    if (empty) begin
                        r_front <= r_node;
                        r_back  <= r_node;
                    end else if (r_alt) begin
                        r_back  <= r_node;
                    end else begin
                        r_front <= r_node;
                    end
                    r_count <= r_count + 1'b1;
                    r_state <= S_EMIT;
                end
                S_LOOK: begin
                    r_state <= r_rm ? S_UNL1 : S_EMIT;
                end
                S_UNL1: begin
                    if (r_count == CNT_W'(1)) begin
                        r_front <= '0;
                        r_back  <= '0;
                    end else if (r_node == r_front) begin
                        r_front <= r_rd_next;
                    end else if (r_node == r_back) begin
                        r_back  <= r_rd_prev;
                    end
                    r_state <= S_UNL2;
                end
                S_UNL2: begin
                    r_free  <= r_node;
                    r_count <= r_count - 1'b1;
                    r_state <= S_EMIT;
                end
                S_SRCH_RD: begin
                    r_state <= (r_idx == r_count) ? S_EMIT : S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    if (r_rd_value == r_word) begin
                        r_state <= r_rm ? S_UNL1 : S_EMIT;
                    end else begin
                        r_state <= S_SRCH_RD;
                    end
                end
                S_DUMP_RD: begin
                    r_dump_ld <= 1'b1;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    r_dump_ld <= 1'b0;
                    if (!r_dump_ld && out_free) begin
                        r_oitem    <= r_item;
                        r_ostatus  <= r_status;
                        r_ocount   <= 7'(r_count);
                        r_olast    <= r_last;
                        r_clr_emit <= 1'b0;
                        r_state    <= r_more ? S_DUMP_RD : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_item   = r_oitem;
    assign o_status = r_ostatus;
    assign o_count  = r_ocount;
    assign o_last   = r_olast;

endmodule

// ----- rtl/linked_list_deque_with_search.sv -----
// Remove and contains walk the list node by node. Dump gives one result beat
// per node; clear sweeps all CAPACITY nodes. All node links sit in single-port
// memories. After reset a sweep over all CAPACITY nodes rebuilds the free
// chain; commands wait in the intake queue (stall high once it fills) until
// the sweep ends.
module linked_list_deque_with_search #(
    parameter int CAPACITY   = lld_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = lld_pkg::WORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [3:0]           i_cmd,
    input  logic signed [31:0]   i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_item,
    output logic [1:0]           o_status,
    output logic [6:0]           o_count,
    output logic                 o_last
);

    // classified commands between intake and execution
    logic           q_valid;
    lld_pkg::t_qent q_entry;
    logic           q_pop;

    // intake: decode each beat and hold it, so new commands land while
    // the back end is still busy with a long walk
    lld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_value   (i_value),
        .o_q_valid (q_valid),
        .o_q_entry (q_entry),
        .i_q_pop   (q_pop)
    );

    // execution: node memories, free chain and the result register
    lld_back #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item),
        .o_status  (o_status),
        .o_count   (o_count),
        .o_last    (o_last)
    );

    // a full list reports exactly its capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == lld_pkg::ST_FULL |-> o_count == 7'(CAPACITY))
        else $error("full status with wrong count");

    // an empty report only comes from an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == lld_pkg::ST_EMPTY |-> o_count == 7'd0)
        else $error("empty status with nonzero count");

    // any failure ends its command
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != lld_pkg::ST_OK |-> o_last)
        else $error("error result not marked last");

endmodule
